FILE: rtl/core/chm_pkg.sv
// Shared types, sizes and the point ordering function for the convex hull core.
package chm_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PTR_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 2);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_point;

    typedef struct packed {
        t_point pt;
        logic   store;
        logic   last;
        logic   drop;
    } t_entry;

    function automatic logic pt_after(input t_point a, input t_point b);
        logic r;
        if (a.x != b.x) begin
            r = (a.x > b.x);
        end else begin
            r = (a.y > b.y);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/convex_hull_monotone_chain_core.sv
// Top level of the convex hull core: front end, item queue and hull engine.
// Each point is accepted into a four-item queue while the queue is not full; the hull engine
// inserts it into the sorted point store, shifting each larger stored point up one place.
// After the last point the two chain passes run over the sorted points,
// then each hull vertex leaves through the output register, held while the receiver stalls.
// Synchronous active-low reset clears the control state; the stores need no clearing.
module convex_hull_monotone_chain_core import chm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_point_valid,
    output logic               o_point_stall,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic               i_is_last,
    output logic               o_hull_valid,
    input  logic               i_hull_stall,
    output logic signed [15:0] o_hull_x,
    output logic signed [15:0] o_hull_y,
    output logic               o_last_vertex,
    output logic               o_empty_hull,
    output logic               o_dropped_points
);

    logic   q_push, q_pop, q_full, q_empty;
    t_entry f_entry, q_entry;

    chm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_point_valid (i_point_valid),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_is_last     (i_is_last),
        .i_q_full      (q_full),
        .o_point_stall (o_point_stall),
        .o_push        (q_push),
        .o_entry       (f_entry)
    );

    chm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (f_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (q_entry)
    );

    chm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_entry          (q_entry),
        .o_pop            (q_pop),
        .i_hull_stall     (i_hull_stall),
        .o_hull_valid     (o_hull_valid),
        .o_hull_x         (o_hull_x),
        .o_hull_y         (o_hull_y),
        .o_last_vertex    (o_last_vertex),
        .o_empty_hull     (o_empty_hull),
        .o_dropped_points (o_dropped_points)
    );

endmodule

FILE: rtl/core/chm_front.sv
// Input front end: accepts points and classifies each as stored or dropped.
module chm_front import chm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_point_valid,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic               i_is_last,
    input  logic               i_q_full,
    output logic               o_point_stall,
    output logic               o_push,
    output t_entry             o_entry
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             store;

    assign store         = (r_cnt < CNT_W'(MAX_POINTS));
    assign o_point_stall = i_q_full;
    assign o_push        = i_point_valid && !i_q_full;

    always_comb begin
        o_entry.pt.x  = i_point_x;
        o_entry.pt.y  = i_point_y;
        o_entry.store = store;
        o_entry.last  = i_is_last;
        o_entry.drop  = r_ovf || !store;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (o_push) begin
            if (i_is_last) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end else begin
                n_cnt = r_cnt + CNT_W'(store);
                n_ovf = r_ovf || !store;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS)) else $error("point count above capacity");

endmodule

FILE: rtl/core/chm_queue.sv
// Short queue of classified items between the front end and the hull engine.
module chm_queue import chm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_entry
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");

endmodule

FILE: rtl/core/chm_back.sv
// Hull engine: insertion sort into the point store, monotone chain passes, vertex output.
module chm_back import chm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_entry             i_entry,
    output logic               o_pop,
    input  logic               i_hull_stall,
    output logic               o_hull_valid,
    output logic signed [15:0] o_hull_x,
    output logic signed [15:0] o_hull_y,
    output logic               o_last_vertex,
    output logic               o_empty_hull,
    output logic               o_dropped_points
);

    typedef enum logic [3:0] {
        S_IDLE, S_SHIFT, H_START, H_FETCH, H_LOAD, H_CHK, H_CMP, H_REFILL,
        O_START, O_RD, O_WAIT
    } t_state;

    t_point r_store [MAX_POINTS];
    t_point r_stack [MAX_POINTS+1];
    t_point r_srd, r_hrd;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_n, n_n, r_j, n_j, r_depth, n_depth, r_floor, n_floor;
    logic [PTR_W-1:0]   r_k, n_k;
    logic               r_upper, n_upper, r_last, n_last, r_drop, n_drop;
    t_point             r_v, n_v, r_p, n_p, r_top1, n_top1, r_top2, n_top2;
    logic signed [33:0] r_m1, n_m1, r_m2, n_m2;
    logic               r_ov, n_ov;
    logic signed [15:0] r_ox, n_ox, r_oy, n_oy;
    logic               r_olast, n_olast, r_oempty, n_oempty, r_odrop, n_odrop;

    logic               s_we, h_we, do_push, out_free;
    logic [PTR_W-1:0]   s_waddr, s_raddr;
    t_point             s_wdata;
    logic [CNT_W-1:0]   h_raddr, n_m1c, j_m1, j_m2, d_m3;
    logic signed [16:0] ax, ay, bx, by;

    assign j_m1     = r_j - 1'b1;
    assign j_m2     = r_j - 2'd2;
    assign n_m1c    = r_n - 1'b1;
    assign d_m3     = r_depth - 2'd3;
    assign out_free = !r_ov || !i_hull_stall;

    assign ax = 17'(r_top1.x) - 17'(r_top2.x);
    assign ay = 17'(r_top1.y) - 17'(r_top2.y);
    assign bx = 17'(r_p.x) - 17'(r_top2.x);
    assign by = 17'(r_p.y) - 17'(r_top2.y);

    always_comb begin
        n_state = r_state;
        n_n = r_n;  n_j = r_j;  n_depth = r_depth;  n_floor = r_floor;
        n_k = r_k;  n_upper = r_upper;  n_last = r_last;  n_drop = r_drop;
        n_v = r_v;  n_p = r_p;  n_top1 = r_top1;  n_top2 = r_top2;
        n_m1 = r_m1;  n_m2 = r_m2;
        n_ov = r_ov && i_hull_stall;
        n_ox = r_ox;  n_oy = r_oy;  n_olast = r_olast;
        n_oempty = r_oempty;  n_odrop = r_odrop;
        o_pop = 1'b0;
        s_we = 1'b0;  s_waddr = r_j[PTR_W-1:0];  s_wdata = r_v;  s_raddr = r_k;
        h_we = 1'b0;  h_raddr = r_j;
        do_push = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop  = 1'b1;
                    n_last = i_entry.last;
                    n_drop = i_entry.drop;
                    if (i_entry.store) begin
                        n_v     = i_entry.pt;
                        n_j     = r_n;
                        n_n     = r_n + 1'b1;
                        s_raddr = n_m1c[PTR_W-1:0];
                        n_state = S_SHIFT;
                    end else if (i_entry.last) begin
                        n_state = H_START;
                    end
                end
            end
            S_SHIFT: begin
                s_we = 1'b1;
                if (r_j != '0 && pt_after(r_srd, r_v)) begin
                    s_wdata = r_srd;
                    n_j     = j_m1;
                    s_raddr = j_m2[PTR_W-1:0];
                end else begin
                    s_wdata = r_v;
                    n_state = r_last ? H_START : S_IDLE;
                end
            end
            H_START: begin
                n_depth = '0;
                n_k     = '0;
                n_upper = 1'b0;
                n_floor = CNT_W'(2);
                n_state = H_FETCH;
            end
            H_FETCH: begin
                n_state = H_LOAD;
            end
            H_LOAD: begin
                n_p     = r_srd;
                n_state = H_CHK;
            end
            H_CHK: begin
                if (r_depth >= r_floor && r_depth >= CNT_W'(2)) begin
                    n_m1    = 34'(ax * by);
                    n_m2    = 34'(ay * bx);
                    n_state = H_CMP;
                end else begin
                    do_push = 1'b1;
                end
            end
            H_CMP: begin
                if (r_m1 <= r_m2) begin
                    n_depth = r_depth - 1'b1;
                    n_top1  = r_top2;
                    if (r_depth >= CNT_W'(3)) begin
                        h_raddr = d_m3;
                        n_state = H_REFILL;
                    end else begin
                        n_state = H_CHK;
                    end
                end else begin
                    do_push = 1'b1;
                end
            end
            H_REFILL: begin
                n_top2  = r_hrd;
                n_state = H_CHK;
            end
            O_START: begin
                if (r_depth == CNT_W'(1)) begin
                    if (out_free) begin
                        n_ov     = 1'b1;
                        n_ox     = '0;
                        n_oy     = '0;
                        n_olast  = 1'b1;
                        n_oempty = 1'b1;
                        n_odrop  = r_drop;
                        n_n      = '0;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_j     = '0;
                    n_state = O_RD;
                end
            end
            O_RD: begin
                n_state = O_WAIT;
            end
            O_WAIT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_ox     = r_hrd.x;
                    n_oy     = r_hrd.y;
                    n_olast  = (r_j + 2'd2 == r_depth);
                    n_oempty = 1'b0;
                    n_odrop  = r_drop;
                    n_j      = r_j + 1'b1;
                    if (r_j + 2'd2 == r_depth) begin
                        n_n     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = O_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_push) begin
            h_we    = 1'b1;
            n_top2  = r_top1;
            n_top1  = r_p;
            n_depth = r_depth + 1'b1;
            if (!r_upper) begin
                if ({1'b0, r_k} == n_m1c) begin
                    n_upper = 1'b1;
                    n_floor = r_depth + 2'd2;
                    if (r_k == '0) begin
                        n_state = O_START;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = H_FETCH;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = H_FETCH;
                end
            end else begin
                if (r_k == '0) begin
                    n_state = O_START;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = H_FETCH;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_store[s_waddr] <= s_wdata;
        end
        r_srd <= r_store[s_raddr];
        if (h_we) begin
            r_stack[r_depth] <= r_p;
        end
        r_hrd <= r_stack[h_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ov    <= n_ov;
        end
        r_j <= n_j;  r_depth <= n_depth;  r_floor <= n_floor;  r_k <= n_k;
        r_upper <= n_upper;  r_last <= n_last;  r_drop <= n_drop;
        r_v <= n_v;  r_p <= n_p;  r_top1 <= n_top1;  r_top2 <= n_top2;
        r_m1 <= n_m1;  r_m2 <= n_m2;
        r_ox <= n_ox;  r_oy <= n_oy;  r_olast <= n_olast;
        r_oempty <= n_oempty;  r_odrop <= n_odrop;
    end

    assign o_hull_valid     = r_ov;
    assign o_hull_x         = r_ox;
    assign o_hull_y         = r_oy;
    assign o_last_vertex    = r_olast;
    assign o_empty_hull     = r_oempty;
    assign o_dropped_points = r_odrop;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(MAX_POINTS)) else $error("stored point count above capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_j < r_n)) else $error("sort index past stored points");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == H_CHK || r_state == H_CMP) |-> (r_depth <= CNT_W'(MAX_POINTS + 1)))
        else $error("hull stack overflow");

endmodule

FILE: tb/convex_hull_monotone_chain_core_tb.sv
// Self-checking testbench for the convex hull core: directed and random point sets against a hull predictor.
module convex_hull_monotone_chain_core_tb;
    import chm_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last_v;
        logic               empty;
        logic               dropped;
    } vertex_t;

    int error_count = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    class hull_scoreboard;
        t_point  pts[$];
        bit      overflow;
        vertex_t pending[$];

        function automatic longint turn(t_point o, t_point a, t_point b);
            longint ax, ay, bx, by;
            ax = longint'(a.x) - longint'(o.x);
            ay = longint'(a.y) - longint'(o.y);
            bx = longint'(b.x) - longint'(o.x);
            by = longint'(b.y) - longint'(o.y);
            return ax * by - ay * bx;
        endfunction

        function automatic bit later(t_point a, t_point b);
            if (a.x != b.x) return a.x > b.x;
            return a.y > b.y;
        endfunction

        function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
            t_point p;
            t_point srt[$];
            t_point stk[$];
            int     j, lower_floor, size;
            vertex_t v;
            p.x = x;
            p.y = y;
            if (pts.size() < MAX_POINTS) pts.push_back(p);
            else overflow = 1;
            if (!last) return;
            foreach (pts[i]) begin
                j = srt.size();
                while (j > 0 && later(srt[j-1], pts[i])) j--;
                srt.insert(j, pts[i]);
            end
            foreach (srt[i]) begin
                while (stk.size() >= 2 &&
                       turn(stk[stk.size()-2], stk[stk.size()-1], srt[i]) <= 0)
                    void'(stk.pop_back());
                stk.push_back(srt[i]);
            end
            lower_floor = stk.size() + 1;
            for (int i = srt.size() - 1; i > 0; i--) begin
                while (stk.size() >= lower_floor && stk.size() >= 2 &&
                       turn(stk[stk.size()-2], stk[stk.size()-1], srt[i-1]) <= 0)
                    void'(stk.pop_back());
                stk.push_back(srt[i-1]);
            end
            size = stk.size() > 0 ? stk.size() - 1 : 0;
            if (size == 0) begin
                v.x = 0; v.y = 0; v.last_v = 1; v.empty = 1; v.dropped = overflow;
                pending.push_back(v);
            end else begin
                for (int i = 0; i < size; i++) begin
                    v.x = stk[i].x; v.y = stk[i].y; v.last_v = (i == size - 1);
                    v.empty = 0; v.dropped = overflow;
                    pending.push_back(v);
                end
            end
            pts.delete();
            overflow = 0;
        endfunction

        task check_vertex(vertex_t got);
            vertex_t e;
            if (pending.size() == 0) begin
                report_mismatch("hull result with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.empty !== e.empty || got.last_v !== e.last_v ||
                got.dropped !== e.dropped ||
                (!e.empty && (got.x !== e.x || got.y !== e.y)))
                report_mismatch($sformatf("got (%0d,%0d) l%b e%b d%b exp (%0d,%0d) l%b e%b d%b",
                    got.x, got.y, got.last_v, got.empty, got.dropped,
                    e.x, e.y, e.last_v, e.empty, e.dropped));
        endtask
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_point_valid = 0;
    logic               o_point_stall;
    logic signed [15:0] i_point_x = 0;
    logic signed [15:0] i_point_y = 0;
    logic               i_is_last = 0;
    logic               o_hull_valid;
    logic               i_hull_stall = 1;
    logic signed [15:0] o_hull_x;
    logic signed [15:0] o_hull_y;
    logic               o_last_vertex;
    logic               o_empty_hull;
    logic               o_dropped_points;

    convex_hull_monotone_chain_core DUT (.*);

    always #4 i_clk = ~i_clk;

    hull_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  long_hold = 0;
    localparam int WATCHDOG = 40000;

    always @(posedge i_clk) begin
        vertex_t g;
        if (i_rst_n) begin
            if (i_point_valid && !o_point_stall)
                sb.note_point(i_point_x, i_point_y, i_is_last);
            if (o_hull_valid && !i_hull_stall) begin
                g.x = o_hull_x; g.y = o_hull_y; g.last_v = o_last_vertex;
                g.empty = o_empty_hull; g.dropped = o_dropped_points;
                sb.check_vertex(g);
            end
            if ((i_point_valid && !o_point_stall) || (o_hull_valid && !i_hull_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("convex_hull_monotone_chain_core_tb: errors");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, with one long hold while the sender keeps offering.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_hull_stall <= 1;
                for (int k = 0; k < 600; k++) @(negedge i_clk);
                long_hold = 0;
            end
            n = gap_len();
            if ($urandom_range(0, 3) == 0 && n > 0) begin
                i_hull_stall <= 1;
                repeat (n) @(negedge i_clk);
            end
            i_hull_stall <= 0;
        end
    end

    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_point_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_point_valid <= 1;
        i_point_x <= x;
        i_point_y <= y;
        i_is_last <= last;
        @(posedge i_clk);
        while (o_point_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_point_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_set(input int n, input int range_w);
        logic signed [15:0] x, y;
        for (int i = 0; i < n; i++) begin
            if (range_w >= 16) begin
                x = 16'($urandom); y = 16'($urandom);
            end else begin
                x = 16'($urandom_range(0, (1 << range_w) - 1) - (1 << (range_w - 1)));
                y = 16'($urandom_range(0, (1 << range_w) - 1) - (1 << (range_w - 1)));
            end
            send_point(x, y, i == n - 1);
        end
    endtask

    initial begin
        int sent;
        int n;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // Directed sets: single point, coincident points, collinear, extreme square, nearly collinear triangle.
        send_point(16'sh7fff, -16'sh8000, 1);
        send_point(5, 5, 0); send_point(5, 5, 1);
        send_point(0, 0, 0); send_point(1, 1, 0); send_point(2, 2, 0); send_point(3, 3, 1);
        send_point(-16'sh8000, -16'sh8000, 0); send_point(16'sh7fff, -16'sh8000, 0);
        send_point(16'sh7fff, 16'sh7fff, 0); send_point(-16'sh8000, 16'sh7fff, 0);
        send_point(0, 0, 0); send_point(16'sh7fff, 16'sh7fff, 1);
        send_point(-16'sh5556, 16'sh2aaa, 0); send_point(16'sh5555, -16'sh2aab, 0);
        send_point(-1, -1, 1);
        // Pause until every expected vertex has come.
        drain();
        // Overflow: more points than the store holds.
        send_set(MAX_POINTS + 3, 16);
        // Long receiver hold while several sets stream in.
        long_hold = 1;
        for (int s = 0; s < 4; s++) send_set($urandom_range(3, 8), 16);
        sent = 0;
        while (sent < 320) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, MAX_POINTS)
                                             : $urandom_range(1, 10);
            send_set(n, ($urandom_range(0, 2) == 0) ? $urandom_range(2, 5) : 16);
            sent += n;
        end
        i_point_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (error_count == 0 && sb.pending.size() == 0)
            $display("convex_hull_monotone_chain_core_tb: clean");
        else
            $display("convex_hull_monotone_chain_core_tb: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/chm_pkg.sv
rtl/core/chm_front.sv
rtl/core/chm_queue.sv
rtl/core/chm_back.sv
rtl/core/convex_hull_monotone_chain_core.sv
tb/convex_hull_monotone_chain_core_tb.sv
